>>> sv/arsl_pkg.sv
// Package for the address range symbol lookup unit.
// Holds field widths, command and register codes, and the shared structs.
// Used by every other file of the block but arsl_ram.
`default_nettype none

package arsl_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 64;
	localparam int NAME_OFS_W = 32;
	localparam int INDEX_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NAMES_LENGTH = 8'd1;

	// One table slot as it is kept in memory.
	typedef struct packed {
		logic [ADDR_W-1:0]     start;
		logic [LEN_W-1:0]      length;
		logic [NAME_OFS_W-1:0] sym_ofs;
		logic                  glb;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic write_entry;
		logic start;
		logic advance;
		logic finish;
		logic deliver;
	} ctrl_cmd_t;

	typedef struct packed {
		logic table_empty;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> sv/arsl_req_if.sv
// Request channel of the lookup unit: load and lookup items.
// Depends on arsl_pkg for field widths.
`default_nettype none

interface arsl_req_if
	import arsl_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [INDEX_W-1:0]    entry_index;
	logic [ADDR_W-1:0]     entry_start;
	logic [LEN_W-1:0]      entry_length;
	logic [NAME_OFS_W-1:0] entry_name_offset;
	logic                  entry_global;
	logic [ADDR_W-1:0]     query_address;

	modport source (
		output valid, cmd, entry_index, entry_start, entry_length,
		       entry_name_offset, entry_global, query_address,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, entry_start, entry_length,
		       entry_name_offset, entry_global, query_address,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/arsl_rsp_if.sv
// Response channel of the lookup unit: one result per lookup item.
// Depends on arsl_pkg for field widths.
`default_nettype none

interface arsl_rsp_if
	import arsl_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [ADDR_W-1:0]     hit_start;
	logic [LEN_W-1:0]      hit_length;
	logic [NAME_OFS_W-1:0] hit_name_offset;
	logic                  hit_name_valid;
	logic                  hit_global;

	modport source (
		output valid, found, hit_start, hit_length, hit_name_offset,
		       hit_name_valid, hit_global,
		input  ready
	);
	modport sink (
		input  valid, found, hit_start, hit_length, hit_name_offset,
		       hit_name_valid, hit_global,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/arsl_cfg_if.sv
// Configuration write channel of the lookup unit.
// Depends on arsl_pkg for index and data widths.
`default_nettype none

interface arsl_cfg_if
	import arsl_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/arsl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module arsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/arsl_ctrl.sv
// Controller state machine of the lookup unit: sequences load, scan and delivery.
// Depends on arsl_pkg for the command and status structs.
`default_nettype none

module arsl_ctrl
	import arsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic       req_cmd,
	output logic            req_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_SCAN    = 3'b010,
		ST_DELIVER = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_cmd == CMD_LOAD) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = status.table_empty ? ST_DELIVER : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					cmd.finish = 1'b1;
					state_d = ST_DELIVER;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_DELIVER: begin
				if (status.out_free) begin
					cmd.deliver = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/arsl_dp.sv
// Datapath of the lookup unit: configuration registers, entry table, scan
// compare, result holding and output register. Depends on arsl_pkg and arsl_ram.
`default_nettype none

module arsl_dp
	import arsl_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 status,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [INDEX_W-1:0]    entry_index,
	input  wire logic [ADDR_W-1:0]     entry_start,
	input  wire logic [LEN_W-1:0]      entry_length,
	input  wire logic [NAME_OFS_W-1:0] entry_name_offset,
	input  wire logic                  entry_global,
	input  wire logic [ADDR_W-1:0]     query_address,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic                       found,
	output logic      [ADDR_W-1:0]     hit_start,
	output logic      [LEN_W-1:0]      hit_length,
	output logic      [NAME_OFS_W-1:0] hit_name_offset,
	output logic                       hit_name_valid,
	output logic                       hit_global
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int LW  = AW + 1;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	logic [COUNT_W-1:0]    entry_count_q;
	logic [NAME_OFS_W-1:0] name_area_len_q;

	logic [ADDR_W-1:0] addr_q;
	logic [LW-1:0]     limit_q;
	logic [AW-1:0]     pos_q;
	logic              prev_valid_q;
	entry_t            prev_q;
	logic              hold_found_q;
	entry_t            hold_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic              out_name_valid_q;
	entry_t            out_q;

	logic [31:0]   count32;
	logic [31:0]   limit32;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          slot_ok;
	entry_t        wr_entry;
	entry_t        rd_entry;
	logic [LW-1:0] pos_next;
	logic [ADDR_W-1:0] end_addr;
	logic          addr_below;
	logic          hit;
	logic          last;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			name_area_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRY_COUNT:  entry_count_q   <= cfg_data[COUNT_W-1:0];
				CFG_NAMES_LENGTH: name_area_len_q <= cfg_data[NAME_OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry count saturates at the table depth.
	assign count32 = 32'(entry_count_q);
	assign limit32 = (count32 > DEPTH32) ? DEPTH32 : count32;

	assign slot_ok  = 32'(entry_index) < DEPTH32;
	assign waddr    = AW'(entry_index);
	assign wr_entry = '{start: entry_start, length: entry_length,
		sym_ofs: entry_name_offset, glb: entry_global};

	assign pos_next = {1'b0, pos_q} + LW'(1);
	assign raddr    = cmd.start ? '0 : pos_next[AW-1:0];

	arsl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.write_entry && slot_ok),
		.waddr (waddr),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	// Compare the slot whose data arrived this cycle against the query.
	assign end_addr   = rd_entry.start + rd_entry.length;
	assign addr_below = rd_entry.start > addr_q;
	assign hit        = !addr_below && (addr_q < end_addr);
	assign last       = pos_next == limit_q;

	assign status.table_empty = limit32 == 32'd0;
	assign status.scan_done   = addr_below || hit || last;
	assign status.out_free    = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			prev_valid_q <= 1'b0;
			hold_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				pos_q        <= '0;
				prev_valid_q <= 1'b0;
				hold_found_q <= 1'b0;
			end else if (cmd.advance) begin
				pos_q        <= pos_next[AW-1:0];
				prev_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_found_q <= hit || (addr_below && prev_valid_q);
			end
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q  <= query_address;
			limit_q <= LW'(limit32);
			hold_q  <= '0;
		end
		if (cmd.advance) begin
			prev_q <= rd_entry;
		end
		if (cmd.finish) begin
			if (hit) begin
				hold_q <= rd_entry;
			end else if (addr_below && prev_valid_q) begin
				hold_q <= prev_q;
			end else begin
				hold_q <= '0;
			end
		end
		if (cmd.deliver) begin
			out_found_q      <= hold_found_q;
			out_q            <= hold_q;
			out_name_valid_q <= hold_found_q && (hold_q.sym_ofs < name_area_len_q);
		end
	end

	assign rsp_valid       = out_valid_q;
	assign found           = out_found_q;
	assign hit_start       = out_q.start;
	assign hit_length      = out_q.length;
	assign hit_name_offset = out_q.sym_ofs;
	assign hit_name_valid  = out_name_valid_q;
	assign hit_global      = out_q.glb;

endmodule

`default_nettype wire

>>> sv/address_range_symbol_lookup_unit.sv
// Address range symbol lookup unit: resolves an address to a symbol entry.
// Items arrive on req; a load (cmd 0) writes one table slot and gives no
// result, a lookup (cmd 1) gives exactly one result on rsp. Registers are
// written on cfg (index 0: entry count, index 1: names length); cfg is
// always ready and is meant to be written while the unit is idle.
// Slots are assumed sorted by start address. A lookup scans slots from zero,
// one slot per cycle, limited by the entry count (saturated at TABLE_DEPTH).
// A load is taken in idle and the next item may follow directly. A lookup
// goes from idle to scan, which stops at a hit, at a start above the
// address or at the last counted slot (an empty table skips the scan), then
// to deliver, which loads the output register once it is free, then to idle.
// The next item is taken only once the lookup is back in idle.
// The result sits in an output register: while the receiver stalls, the unit
// already takes the next item, and a finished lookup waits for that register.
// Reset clears the registers to zero and the control logic to idle; table
// contents are undefined until loaded, and no clearing pass runs.
// Depends on arsl_pkg, the three channel interfaces, arsl_ctrl and arsl_dp.
`default_nettype none

module address_range_symbol_lookup_unit
	import arsl_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	arsl_req_if.sink   req,
	arsl_rsp_if.source rsp,
	arsl_cfg_if.sink   cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       req_ready;

	assign req.ready = req_ready;
	assign cfg.ready = 1'b1;

	arsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	arsl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.entry_index       (req.entry_index),
		.entry_start       (req.entry_start),
		.entry_length      (req.entry_length),
		.entry_name_offset (req.entry_name_offset),
		.entry_global      (req.entry_global),
		.query_address     (req.query_address),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.found             (rsp.found),
		.hit_start         (rsp.hit_start),
		.hit_length        (rsp.hit_length),
		.hit_name_offset   (rsp.hit_name_offset),
		.hit_name_valid    (rsp.hit_name_valid),
		.hit_global        (rsp.hit_global)
	);

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench of address_range_symbol_lookup_unit: loads symbol tables, looks up
// addresses under random stalls on both channels and checks every result.
// Depends on arsl_pkg, the three channel interfaces and the unit itself.

module tb_top;
	import arsl_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 580;
	localparam int IDLE_PCT = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	// A slow correct run is made of at most about 25 lookups over a full table,
	// some 600 short lookups, ~1700 loads and the stalls; the limit leaves
	// several times the time that these need.
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_DATA_W-1:0] COUNT_MASK = (1 << COUNT_W) - 1;

	typedef struct packed {
		logic                  cmd;
		logic [INDEX_W-1:0]    entry_index;
		logic [ADDR_W-1:0]     entry_start;
		logic [LEN_W-1:0]      entry_length;
		logic [NAME_OFS_W-1:0] entry_name_offset;
		logic                  entry_global;
		logic [ADDR_W-1:0]     query_address;
	} req_item_t;

	typedef struct packed {
		logic                  found;
		logic [ADDR_W-1:0]     start;
		logic [LEN_W-1:0]      length;
		logic [NAME_OFS_W-1:0] sym_ofs;
		logic                  name_valid;
		logic                  glb;
	} hit_t;

	// Keeps its own copy of the symbol table and registers, and the hits that
	// accepted lookups still owe.
	class symbol_hit_board;
		bit [ADDR_W-1:0]     slot_start [DEPTH];
		bit [LEN_W-1:0]      slot_length [DEPTH];
		bit [NAME_OFS_W-1:0] slot_name [DEPTH];
		bit                  slot_glb [DEPTH];
		bit [COUNT_W-1:0]    entry_count;
		bit [CFG_DATA_W-1:0] name_area_len;
		hit_t                pending_hits[$];
		int unsigned         mismatches;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_ENTRY_COUNT) begin
				entry_count = data[COUNT_W-1:0];
			end else if (idx == CFG_NAMES_LENGTH) begin
				name_area_len = data;
			end
		endfunction

		// Scan from slot zero: a start above the address returns the slot
		// before it, a range holding the address returns that slot.
		function hit_t resolve_address(logic [ADDR_W-1:0] addr);
			int limit;
			int prev;
			int slot;
			bit [ADDR_W-1:0] stop;
			hit_t h;
			limit = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
			prev = -1;
			slot = -1;
			for (int i = 0; i < limit; i++) begin
				stop = slot_start[i] + slot_length[i];
				if (slot_start[i] > addr) begin
					slot = prev;
					break;
				end
				if (addr < stop) begin
					slot = i;
					break;
				end
				prev = i;
			end
			h = '0;
			if (slot >= 0) begin
				h.found = 1'b1;
				h.start = slot_start[slot];
				h.length = slot_length[slot];
				h.sym_ofs = slot_name[slot];
				h.name_valid = slot_name[slot] < name_area_len;
				h.glb = slot_glb[slot];
			end
			return h;
		endfunction

		function void take_item(req_item_t it);
			if (it.cmd == CMD_LOAD) begin
				if (it.entry_index < DEPTH) begin
					slot_start[it.entry_index] = it.entry_start;
					slot_length[it.entry_index] = it.entry_length;
					slot_name[it.entry_index] = it.entry_name_offset;
					slot_glb[it.entry_index] = it.entry_global;
				end
			end else begin
				pending_hits.push_back(resolve_address(it.query_address));
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_hit(hit_t got);
			hit_t want;
			if (pending_hits.size() == 0) begin
				report($sformatf("result with no lookup pending, start %h", got.start));
				return;
			end
			want = pending_hits.pop_front();
			if (got.found !== want.found)
				report($sformatf("found %b, expected %b", got.found, want.found));
			if (got.start !== want.start)
				report($sformatf("hit_start %h, expected %h", got.start, want.start));
			if (got.length !== want.length)
				report($sformatf("hit_length %h, expected %h", got.length, want.length));
			if (got.sym_ofs !== want.sym_ofs)
				report($sformatf("hit_name_offset %h, expected %h",
					got.sym_ofs, want.sym_ofs));
			if (got.name_valid !== want.name_valid)
				report($sformatf("hit_name_valid %b, expected %b",
					got.name_valid, want.name_valid));
			if (got.glb !== want.glb)
				report($sformatf("hit_global %b, expected %b", got.glb, want.glb));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	arsl_req_if req_ch();
	arsl_rsp_if rsp_ch();
	arsl_cfg_if cfg_ch();

	address_range_symbol_lookup_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	symbol_hit_board board;
	int idle_pct = IDLE_PCT;
	bit hold_rsp;
	bit pressure_go;
	int cycle_count;
	int items_sent;
	int loaded_upto;
	bit [ADDR_W-1:0] laid_start [DEPTH];
	bit [LEN_W-1:0] laid_length [DEPTH];
	req_item_t seen_req;
	hit_t seen_hit;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("address_range_symbol_lookup_unit verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				board.set_register(cfg_ch.index, cfg_ch.data);
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_req = {req_ch.cmd, req_ch.entry_index, req_ch.entry_start,
					req_ch.entry_length, req_ch.entry_name_offset, req_ch.entry_global,
					req_ch.query_address};
				board.take_item(seen_req);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_hit = {rsp_ch.found, rsp_ch.hit_start, rsp_ch.hit_length,
					rsp_ch.hit_name_offset, rsp_ch.hit_name_valid, rsp_ch.hit_global};
				board.check_hit(seen_hit);
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= idle_pct);
		end
	end

	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	function automatic req_item_t noise_item();
		req_item_t it;
		it.cmd = CMD_LOOKUP;
		it.entry_index = INDEX_W'($urandom);
		it.entry_start = {$urandom, $urandom};
		it.entry_length = {$urandom, $urandom};
		it.entry_name_offset = $urandom;
		it.entry_global = 1'($urandom_range(0, 1));
		it.query_address = {$urandom, $urandom};
		return it;
	endfunction

	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= it.cmd;
		req_ch.entry_index <= it.entry_index;
		req_ch.entry_start <= it.entry_start;
		req_ch.entry_length <= it.entry_length;
		req_ch.entry_name_offset <= it.entry_name_offset;
		req_ch.entry_global <= it.entry_global;
		req_ch.query_address <= it.query_address;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_slot(input int idx, input logic [ADDR_W-1:0] start,
		input logic [LEN_W-1:0] len, input logic [NAME_OFS_W-1:0] ofs, input logic glb);
		req_item_t it;
		it = noise_item();
		it.cmd = CMD_LOAD;
		it.entry_index = INDEX_W'(idx);
		it.entry_start = start;
		it.entry_length = len;
		it.entry_name_offset = ofs;
		it.entry_global = glb;
		laid_start[idx] = start;
		laid_length[idx] = len;
		if (idx == loaded_upto) loaded_upto++;
		send_item(it);
	endtask

	task automatic look_up(input logic [ADDR_W-1:0] addr);
		req_item_t it;
		it = noise_item();
		it.query_address = addr;
		send_item(it);
	endtask

	// A second write follows only after valid has gone low.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every lookup has answered, then give a trailing load time to
	// land before the registers change.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_names_length();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(1, 300);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [NAME_OFS_W-1:0] pick_name_offset(input logic [CFG_DATA_W-1:0] nl);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return nl;
			2: return nl - 1;
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address(input int n);
		int j;
		logic [ADDR_W-1:0] s;
		logic [LEN_W-1:0] l;
		j = (n > 0) ? $urandom_range(0, n - 1) : 0;
		s = laid_start[j];
		l = laid_length[j];
		case ($urandom_range(0, 9))
			0: return s;
			1: return s + l - 1;
			2: return s + l;
			3: return s - 1;
			4: return (l != 0) ? s + ({$urandom, $urandom} % l) : s;
			5: return '0;
			6: return '1;
			7: return {$urandom, $urandom};
			default: return s + ADDR_W'($urandom_range(0, 40));
		endcase
	endfunction

	// Mostly ascending, non-overlapping slots; now and then a slot out of
	// order, an empty range, or a last slot whose end wraps past the top.
	task automatic load_table(input int n, input logic [CFG_DATA_W-1:0] nl);
		logic [ADDR_W-1:0] cur;
		logic [LEN_W-1:0] len;
		case ($urandom_range(0, 7))
			0: cur = '0;
			1: cur = '1 - ADDR_W'($urandom_range(0, 4000));
			2, 3: cur = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: cur = ADDR_W'($urandom_range(0, 1000));
		endcase
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 15))
				0: len = '0;
				1: len = (i == n - 1) ? {$urandom, $urandom} : 64'd1;
				default: len = LEN_W'($urandom_range(1, 64));
			endcase
			if ($urandom_range(0, 24) == 0) cur = {$urandom, $urandom};
			load_slot(i, cur, len, pick_name_offset(nl), 1'($urandom_range(0, 1)));
			cur = cur + len + ADDR_W'($urandom_range(0, 24));
		end
	endtask

	task automatic directed_part();
		// Right after reset the entry count is zero: no table.
		look_up(64'd40);
		settle();
		write_reg(CFG_NAMES_LENGTH, 32'd100);
		write_reg(CFG_ENTRY_COUNT, 32'd4);
		load_slot(0, 64'd8, 64'd16, 32'd5, 1'b1);
		load_slot(1, 64'd32, 64'd0, 32'd100, 1'b0);
		load_slot(2, 64'd64, '1, 32'd99, 1'b1);
		load_slot(3, 64'hFFFF_FFFF_FFFF_FFF0, 64'd8, '1, 1'b1);
		look_up(64'd0);
		look_up(64'd8);
		look_up(64'd23);
		look_up(64'd24);
		look_up(64'd32);
		look_up(64'd100);
		look_up(64'hFFFF_FFFF_FFFF_FFF4);
		look_up('1);
		settle();
		// Writes to indexes past the register list must change nothing.
		write_reg(CFG_IDX_W'(CFG_NAMES_LENGTH + 1), $urandom);
		write_reg('1, $urandom);
		write_reg(CFG_NAMES_LENGTH, '1);
		look_up(64'd32);
		look_up(64'hFFFF_FFFF_FFFF_FFF4);
		settle();
		// Only the low bits of the data count: this leaves one slot.
		write_reg(CFG_ENTRY_COUNT, ~COUNT_MASK | 32'd1);
		look_up(64'd100);
		look_up(64'd10);
	endtask

	task automatic full_table_phase();
		logic [CFG_DATA_W-1:0] nl;
		settle();
		nl = pick_names_length();
		write_reg(CFG_NAMES_LENGTH, nl);
		write_reg(CFG_ENTRY_COUNT, DEPTH);
		load_table(DEPTH, nl);
		look_up('1);
		repeat (4) look_up(pick_address(DEPTH));
		settle();
		// A count beyond the table depth must stop the scan at the last slot.
		write_reg(CFG_ENTRY_COUNT, COUNT_MASK);
		look_up('1);
		look_up(laid_start[DEPTH-1]);
		settle();
		write_reg(CFG_ENTRY_COUNT, DEPTH - 1);
		look_up('1);
		look_up(laid_start[DEPTH-1]);
	endtask

	task automatic random_phase(input int count, input int items, input bit squeeze);
		logic [CFG_DATA_W-1:0] nl;
		logic [CFG_DATA_W-1:0] junk;
		int n;
		int j;
		settle();
		nl = pick_names_length();
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_IDX_W'($urandom_range(CFG_NAMES_LENGTH + 1, 255)), $urandom);
		end
		write_reg(CFG_NAMES_LENGTH, nl);
		junk = ($urandom_range(0, 3) == 0) ? ($urandom & ~COUNT_MASK) : '0;
		write_reg(CFG_ENTRY_COUNT, junk | CFG_DATA_W'(count));
		n = (count > DEPTH) ? DEPTH : count;
		if (n > loaded_upto || (n <= 64 && $urandom_range(0, 3) != 0)) begin
			load_table(n, nl);
		end
		if (squeeze) pressure_go <= 1'b1;
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				j = $urandom_range(0, DEPTH - 1);
				load_slot(j, (j < n) ? laid_start[j] : {$urandom, $urandom},
					LEN_W'($urandom_range(0, 64)), pick_name_offset(nl),
					1'($urandom_range(0, 1)));
			end else begin
				look_up(pick_address(n));
			end
		end
	endtask

	initial begin
		int count;
		int items;
		int sel;
		int phase;
		int big_phases;
		int budget_end;
		board = new();
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_LOAD;
		req_ch.entry_index <= '0;
		req_ch.entry_start <= '0;
		req_ch.entry_length <= '0;
		req_ch.entry_name_offset <= '0;
		req_ch.entry_global <= 1'b0;
		req_ch.query_address <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ENTRY_COUNT;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();
		full_table_phase();

		budget_end = items_sent + RANDOM_ITEMS;
		phase = 0;
		big_phases = 0;
		while (items_sent < budget_end) begin
			// A few phases run with no idle cycles on either side.
			idle_pct = (phase >= 3 && phase < 6) ? 0 : IDLE_PCT;
			sel = $urandom_range(0, 19);
			if (phase == 1) begin
				count = 8;
				items = 40;
			end else if (sel == 0 && big_phases < 3) begin
				case ($urandom_range(0, 3))
					0: count = DEPTH - 1;
					1: count = DEPTH;
					2: count = COUNT_MASK;
					default: count = $urandom_range(DEPTH + 1, COUNT_MASK - 1);
				endcase
				items = 4;
				big_phases++;
			end else if (sel < 3) begin
				count = 0;
				items = 6;
			end else if (sel < 6) begin
				count = $urandom_range(17, 64);
				items = 20;
			end else begin
				count = $urandom_range(1, 16);
				items = $urandom_range(10, 30);
			end
			random_phase(count, items, phase == 1);
			phase++;
		end
		idle_pct = IDLE_PCT;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("address_range_symbol_lookup_unit verification clean");
		end else begin
			$display("address_range_symbol_lookup_unit verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/arsl_pkg.sv
sv/arsl_req_if.sv
sv/arsl_rsp_if.sv
sv/arsl_cfg_if.sv
sv/arsl_ram.sv
sv/arsl_ctrl.sv
sv/arsl_dp.sv
sv/address_range_symbol_lookup_unit.sv
sim/tb_top.sv
